// ===== hw/rtl/cpsb_pkg.sv =====
// Package for the column-post sprite blitter: payload word types, parse phases,
// opcode and result kind codes, screen geometry constants.
// No dependencies.
package cpsb_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;
    localparam int MAX_SCREEN    = 4;

    localparam logic [7:0] END_MARK = 8'hff;

    localparam logic [1:0] OP_BEGIN_PATCH  = 2'd0;
    localparam logic [1:0] OP_BEGIN_COLUMN = 2'd1;
    localparam logic [1:0] OP_DATA         = 2'd2;

    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_ACCEPT = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_TOP  = 3'd1,
        PH_LEN  = 3'd2,
        PH_PAD1 = 3'd3,
        PH_PIX  = 3'd4,
        PH_PAD2 = 3'd5,
        PH_DONE = 3'd6
    } t_phase;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [14:0]        patch_width;
        logic [14:0]        patch_height;
        logic signed [15:0] left_offset;
        logic signed [15:0] top_offset;
        logic [2:0]         screen_select;
        logic               mirror;
        logic [14:0]        column_index;
        logic [7:0]         data_byte;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  target_screen;
        logic [15:0] pixel_address;
        logic [7:0]  pixel_value;
    } t_out_word;

endpackage

// ===== hw/rtl/column_post_sprite_blitter_core.sv =====
// Column-post sprite blitter top level: post-stream parser, placement check,
// address generation and output skid. Depends on cpsb_pkg.
//
// Usage:
//   Input channel i_valid / o_stall / i_in carries one word per cycle: a
//   begin-patch word (placement, size, offsets, screen, mirror), a
//   begin-column word (source column) or a column data byte. Output channel
//   o_valid / i_stall / o_out carries pixel writes and patch accept/reject
//   reports; a word moves when valid is high and stall is low.
//   A word accepted at an edge shows its result on o_out after that edge
//   when o_out can take it. Words that cause no result are simply consumed.
//   Throughput: one word per cycle. The parse state is updated in the
//   accept cycle and the result goes to a registered output, so the only
//   limit is the output side: a skid stage holds one extra result, and
//   o_stall rises only while that skid stage is occupied.
//   When the receiver stalls, o_out holds; one more result is absorbed by
//   the skid stage, then input stalls until the output drains.
//   Reset (synchronous, active low) empties both output stages and returns
//   the parser to idle with no patch active.
module column_post_sprite_blitter_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  cpsb_pkg::t_in_word  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output cpsb_pkg::t_out_word o_out
);

    // parse state
    cpsb_pkg::t_phase r_phase, n_phase;
    logic        r_patch_acc, n_patch_acc;
    logic [15:0] r_left_edge, n_left_edge;
    logic [15:0] r_top_edge, n_top_edge;
    logic [14:0] r_width, n_width;
    logic        r_mirror, n_mirror;
    logic [2:0]  r_screen, n_screen;
    logic [15:0] r_dest_col, n_dest_col;
    logic [15:0] r_row, n_row;
    logic [7:0]  r_bytes_left, n_bytes_left;

    // output stages
    logic                r_ov, r_sv;
    cpsb_pkg::t_out_word r_out, r_skid;

    logic                w_acc;
    logic                w_take;
    logic                w_res_valid;
    cpsb_pkg::t_out_word w_res;

    logic signed [17:0] w_x, w_y, w_xr, w_yb;
    logic               w_reject;
    logic [14:0]        w_col_idx;
    logic [7:0]         w_bytes_dec;

    assign o_stall = r_sv;
    assign w_acc   = i_valid && !r_sv;
    assign w_take  = r_ov && !i_stall;
    assign o_valid = r_ov;
    assign o_out   = r_out;

    // placement arithmetic
    always_comb begin
        w_x  = 18'(i_in.origin_x) - 18'(i_in.left_offset);
        w_y  = 18'(i_in.origin_y) - 18'(i_in.top_offset);
        w_xr = w_x + signed'(18'(i_in.patch_width));
        w_yb = w_y + signed'(18'(i_in.patch_height));
        w_reject = w_x[17] || w_y[17]
            || (w_xr > signed'(18'(cpsb_pkg::SCREEN_WIDTH)))
            || (w_yb > signed'(18'(cpsb_pkg::SCREEN_HEIGHT)))
            || (i_in.screen_select > 3'(cpsb_pkg::MAX_SCREEN));
        w_col_idx   = r_mirror ? (r_width - 15'd1 - i_in.column_index) : i_in.column_index;
        w_bytes_dec = r_bytes_left - 8'd1;
    end

    // next parse state
    always_comb begin
        n_phase      = r_phase;
        n_patch_acc  = r_patch_acc;
        n_left_edge  = r_left_edge;
        n_top_edge   = r_top_edge;
        n_width      = r_width;
        n_mirror     = r_mirror;
        n_screen     = r_screen;
        n_dest_col   = r_dest_col;
        n_row        = r_row;
        n_bytes_left = r_bytes_left;
        case (i_in.opcode)
            cpsb_pkg::OP_BEGIN_PATCH: begin
                n_phase = cpsb_pkg::PH_IDLE;
                if (w_reject) begin
                    n_patch_acc = 1'b0;
                end else begin
                    n_patch_acc = 1'b1;
                    n_left_edge = w_x[15:0];
                    n_top_edge  = w_y[15:0];
                    n_width     = i_in.patch_width;
                    n_mirror    = i_in.mirror;
                    n_screen    = i_in.screen_select;
                end
            end
            cpsb_pkg::OP_BEGIN_COLUMN: begin
                if (r_patch_acc) begin
                    if (i_in.column_index >= r_width) begin
                        n_phase = cpsb_pkg::PH_DONE;
                    end else begin
                        n_dest_col = r_left_edge + 16'(w_col_idx);
                        n_phase    = cpsb_pkg::PH_TOP;
                    end
                end
            end
            cpsb_pkg::OP_DATA: begin
                if (r_patch_acc) begin
                    case (r_phase)
                        cpsb_pkg::PH_TOP: begin
                            if (i_in.data_byte == cpsb_pkg::END_MARK) begin
                                n_phase = cpsb_pkg::PH_DONE;
                            end else begin
                                n_row   = r_top_edge + 16'(i_in.data_byte);
                                n_phase = cpsb_pkg::PH_LEN;
                            end
                        end
                        cpsb_pkg::PH_LEN: begin
                            n_bytes_left = i_in.data_byte;
                            n_phase      = cpsb_pkg::PH_PAD1;
                        end
                        cpsb_pkg::PH_PAD1: begin
                            n_phase = (r_bytes_left != 8'd0) ? cpsb_pkg::PH_PIX
                                                             : cpsb_pkg::PH_PAD2;
                        end
                        cpsb_pkg::PH_PIX: begin
                            n_row        = r_row + 16'd1;
                            n_bytes_left = w_bytes_dec;
                            if (w_bytes_dec == 8'd0) begin
                                n_phase = cpsb_pkg::PH_PAD2;
                            end
                        end
                        cpsb_pkg::PH_PAD2: begin
                            n_phase = cpsb_pkg::PH_TOP;
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // result word
    always_comb begin
        w_res_valid = 1'b0;
        w_res       = '0;
        case (i_in.opcode)
            cpsb_pkg::OP_BEGIN_PATCH: begin
                w_res_valid = 1'b1;
                if (w_reject) begin
                    w_res.kind = cpsb_pkg::KIND_REJECT;
                end else begin
                    w_res.kind          = cpsb_pkg::KIND_ACCEPT;
                    w_res.target_screen = i_in.screen_select;
                    w_res.pixel_address = w_y[15:0] * 16'(cpsb_pkg::SCREEN_WIDTH)
                                        + w_x[15:0];
                end
            end
            cpsb_pkg::OP_DATA: begin
                // drop pixels that fall below the screen
                if (r_patch_acc && (r_phase == cpsb_pkg::PH_PIX)
                    && (r_row < 16'(cpsb_pkg::SCREEN_HEIGHT))) begin
                    w_res_valid         = 1'b1;
                    w_res.kind          = cpsb_pkg::KIND_PIXEL;
                    w_res.target_screen = r_screen;
                    w_res.pixel_address = r_row * 16'(cpsb_pkg::SCREEN_WIDTH)
                                        + r_dest_col;
                    w_res.pixel_value   = i_in.data_byte;
                end
            end
            default: begin
                w_res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= cpsb_pkg::PH_IDLE;
            r_patch_acc  <= 1'b0;
            r_left_edge  <= '0;
            r_top_edge   <= '0;
            r_width      <= '0;
            r_mirror     <= 1'b0;
            r_screen     <= '0;
            r_dest_col   <= '0;
            r_row        <= '0;
            r_bytes_left <= '0;
        end else if (w_acc) begin
            r_phase      <= n_phase;
            r_patch_acc  <= n_patch_acc;
            r_left_edge  <= n_left_edge;
            r_top_edge   <= n_top_edge;
            r_width      <= n_width;
            r_mirror     <= n_mirror;
            r_screen     <= n_screen;
            r_dest_col   <= n_dest_col;
            r_row        <= n_row;
            r_bytes_left <= n_bytes_left;
        end
    end

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_take) begin
                r_sv <= 1'b0;
            end
        end else if (!r_ov || w_take) begin
            r_ov <= w_acc && w_res_valid;
        end else if (w_acc && w_res_valid) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (!r_ov || w_take) begin
            r_out <= w_res;
        end else begin
            r_skid <= w_res;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid stage full while output register empty");

    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && w_take) |=> (r_ov && !r_sv))
        else $error("skid word not moved to output");

    a_no_pixel_without_patch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && !r_patch_acc && (i_in.opcode != cpsb_pkg::OP_BEGIN_PATCH))
        |-> !w_res_valid)
        else $error("result produced with no patch active");

    a_reject_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.kind == cpsb_pkg::KIND_REJECT))
        |-> ((o_out.target_screen == 3'd0) && (o_out.pixel_address == 16'd0)))
        else $error("rejection carries nonzero fields");

    a_pixel_screen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_out.kind == cpsb_pkg::KIND_PIXEL))
        |-> (o_out.target_screen <= 3'(cpsb_pkg::MAX_SCREEN)))
        else $error("pixel write to an invalid screen");

endmodule
